// ===== sv/sti_pkg.sv =====
package sti_pkg;

  localparam int CH_W    = 8;
  localparam int VALUE_W = 32;
  localparam int BASE_W  = 5;
  localparam int OFF_W   = 8;

  localparam logic [CH_W-1:0] CHAR_MINUS = 8'h2D;  // '-'
  localparam logic [CH_W-1:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [CH_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [CH_W-1:0] CHAR_NINE  = 8'h39;  // '9'
  localparam logic [CH_W-1:0] CHAR_LX    = 8'h78;  // 'x'
  localparam logic [CH_W-1:0] CHAR_UX    = 8'h58;  // 'X'
  localparam logic [CH_W-1:0] CHAR_LA    = 8'h61;  // 'a'
  localparam logic [CH_W-1:0] CHAR_LF    = 8'h66;  // 'f'
  localparam logic [CH_W-1:0] CHAR_UA    = 8'h41;  // 'A'
  localparam logic [CH_W-1:0] CHAR_UF    = 8'h46;  // 'F'
  localparam logic [CH_W-1:0] CASE_DIFF  = 8'h20;

  localparam logic [BASE_W-1:0] BASE_AUTO = 5'd0;
  localparam logic [BASE_W-1:0] BASE_DEC  = 5'd10;
  localparam logic [BASE_W-1:0] BASE_HEX  = 5'd16;

  typedef enum logic [2:0] {
    PH_SIGN   = 3'd0,
    PH_PLUS   = 3'd1,
    PH_PREFIX = 3'd2,
    PH_ZERO   = 3'd3,
    PH_DIGITS = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  // parse control state carried between transactions
  typedef struct packed {
    phase_t              phase;
    logic [BASE_W-1:0]   base;
    logic                neg;
  } ctl_t;

endpackage

// ===== sv/string_to_integer_parser.sv =====
// strtol-style integer parser. Feed a text one character per transaction on
// the in_ stream; in_tuser marks the first character of a string. Every
// character gives one result: the signed value parsed so far (wrapping mod
// 2^32), the offset just past the last consumed character (saturating at 255)
// and a stopped flag that rises at NUL or the first non-digit and then holds
// the final result until the next string starts. Base comes from the cfg
// register (0 = auto 0x/0X detect, else that base, e.g. 10 or 16) and is
// sampled on the first character of each string. Throughput is one
// character per clock while the result stream is not stalled; each character
// passes the s1 input register and then the result register. The clock rate
// is set by the step stage, where the accumulator update is one 32x5 multiply and add.
module string_to_integer_parser #(
  parameter int MAX_CHARS = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,     // number_base
  // character stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] ch
  input  logic [0:0]  in_tuser,     // [0] first
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,    // [31:0] value, [39:32] end_offset
  output logic [0:0]  out_tuser     // [0] stopped
);

  localparam int PW = $clog2(MAX_CHARS + 1);

  // config register
  logic [sti_pkg::BASE_W-1:0] base_r;

  // input register stage
  logic                       s1_valid_r;
  logic [sti_pkg::CH_W-1:0]   s1_ch_r;
  logic                       s1_first_r;

  // parse state
  sti_pkg::ctl_t              ctl_r;
  logic [sti_pkg::VALUE_W-1:0] acc_r;
  logic [PW-1:0]              pos_r;
  logic [PW-1:0]              cend_r;

  sti_pkg::ctl_t              ctl_nxt;
  logic [sti_pkg::VALUE_W-1:0] acc_nxt;
  logic [PW-1:0]              pos_nxt;
  logic [PW-1:0]              cend_nxt;

  logic [sti_pkg::VALUE_W-1:0] value_nxt;
  logic [sti_pkg::OFF_W-1:0]  off_nxt;
  logic                       stop_nxt;

  // result register
  logic                       out_valid_r;
  logic [sti_pkg::VALUE_W-1:0] value_r;
  logic [sti_pkg::OFF_W-1:0]  off_r;
  logic                       stop_r;

  logic advance;

  // step fires when the result register is free or being drained
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= sti_pkg::BASE_AUTO;
    end else if (cfg_valid) begin
      base_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_ch_r    <= in_tdata;
      s1_first_r <= in_tuser[0];
    end
  end

  sti_step #(
    .MAX_CHARS (MAX_CHARS),
    .PW        (PW)
  ) u_step (
    .ch         (s1_ch_r),
    .first      (s1_first_r),
    .cfg_base   (base_r),
    .ctl_cur    (ctl_r),
    .acc_cur    (acc_r),
    .pos_cur    (pos_r),
    .cend_cur   (cend_r),
    .ctl_nxt    (ctl_nxt),
    .acc_nxt    (acc_nxt),
    .pos_nxt    (pos_nxt),
    .cend_nxt   (cend_nxt),
    .value      (value_nxt),
    .end_offset (off_nxt),
    .stopped    (stop_nxt)
  );

  // parse state commits once per character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r  <= '{phase: sti_pkg::PH_SIGN, base: '0, neg: 1'b0};
      acc_r  <= '0;
      pos_r  <= '0;
      cend_r <= '0;
    end else if (advance) begin
      ctl_r  <= ctl_nxt;
      acc_r  <= acc_nxt;
      pos_r  <= pos_nxt;
      cend_r <= cend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      value_r <= value_nxt;
      off_r   <= off_nxt;
      stop_r  <= stop_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {off_r, value_r};
  assign out_tuser  = stop_r;

endmodule

// ===== sv/sti_step.sv =====
module sti_step #(
  parameter int MAX_CHARS = 255,
  parameter int PW        = 8
) (
  input  logic [sti_pkg::CH_W-1:0]     ch,
  input  logic                         first,
  input  logic [sti_pkg::BASE_W-1:0]   cfg_base,
  input  sti_pkg::ctl_t                ctl_cur,
  input  logic [sti_pkg::VALUE_W-1:0]  acc_cur,
  input  logic [PW-1:0]                pos_cur,
  input  logic [PW-1:0]                cend_cur,
  output sti_pkg::ctl_t                ctl_nxt,
  output logic [sti_pkg::VALUE_W-1:0]  acc_nxt,
  output logic [PW-1:0]                pos_nxt,
  output logic [PW-1:0]                cend_nxt,
  output logic [sti_pkg::VALUE_W-1:0]  value,
  output logic [sti_pkg::OFF_W-1:0]    end_offset,
  output logic                         stopped
);

  localparam int OW = (PW > sti_pkg::OFF_W) ? PW : sti_pkg::OFF_W;
  localparam logic [PW:0] MAXC = (PW+1)'(MAX_CHARS);

  logic [PW:0]   pos_inc;
  logic [PW-1:0] cend_sat;
  logic [OW-1:0] cend_ext;

  // consumed end if this character is taken
  assign pos_inc  = {1'b0, (first ? '0 : pos_cur)} + (PW+1)'(1);
  assign cend_sat = (pos_inc > MAXC) ? PW'(MAX_CHARS) : pos_inc[PW-1:0];

  always_comb begin
    sti_pkg::ctl_t               c;
    logic [sti_pkg::VALUE_W-1:0] a;
    logic [PW-1:0]               p;
    logic [PW-1:0]               e;
    logic                        handled;
    logic                        is_x;
    logic                        ok;
    logic [sti_pkg::CH_W-1:0]    lc;
    logic [3:0]                  d;

    if (first) begin
      c = '{phase: sti_pkg::PH_SIGN, base: '0, neg: 1'b0};
      a = '0;
      p = '0;
      e = '0;
    end else begin
      c = ctl_cur;
      a = acc_cur;
      p = pos_cur;
      e = cend_cur;
    end
    handled = 1'b0;
    is_x    = 1'b0;
    ok      = 1'b0;
    d       = '0;
    lc      = ((ch >= sti_pkg::CHAR_UA) && (ch <= sti_pkg::CHAR_UF)) ?
              (ch + sti_pkg::CASE_DIFF) : ch;

    if (c.phase != sti_pkg::PH_DONE) begin
      if (c.phase == sti_pkg::PH_SIGN) begin
        c.base  = cfg_base;
        c.phase = sti_pkg::PH_PLUS;
        if (ch == sti_pkg::CHAR_MINUS) begin
          c.neg   = 1'b1;
          e       = cend_sat;
          handled = 1'b1;
        end
      end
      if (!handled && c.phase == sti_pkg::PH_PLUS) begin
        c.phase = sti_pkg::PH_PREFIX;
        if (ch == sti_pkg::CHAR_PLUS) begin
          e       = cend_sat;
          handled = 1'b1;
        end
      end
      if (!handled && c.phase == sti_pkg::PH_PREFIX) begin
        if ((c.base == sti_pkg::BASE_AUTO || c.base == sti_pkg::BASE_HEX) &&
            ch == sti_pkg::CHAR_ZERO) begin
          c.phase = sti_pkg::PH_ZERO;
          e       = cend_sat;
          handled = 1'b1;
        end else begin
          if (c.base == sti_pkg::BASE_AUTO) c.base = sti_pkg::BASE_DEC;
          c.phase = sti_pkg::PH_DIGITS;
        end
      end
      if (!handled && c.phase == sti_pkg::PH_ZERO) begin
        is_x = (ch == sti_pkg::CHAR_LX) ||
               (c.base == sti_pkg::BASE_AUTO && ch == sti_pkg::CHAR_UX);
        c.phase = sti_pkg::PH_DIGITS;
        if (is_x) begin
          c.base  = sti_pkg::BASE_HEX;
          e       = cend_sat;
          handled = 1'b1;
        end else if (c.base == sti_pkg::BASE_AUTO) begin
          c.base = sti_pkg::BASE_DEC;
        end
      end
      if (!handled && c.phase == sti_pkg::PH_DIGITS) begin
        if (ch >= sti_pkg::CHAR_ZERO && ch <= sti_pkg::CHAR_NINE) begin
          ok = 1'b1;
          d  = 4'(ch - sti_pkg::CHAR_ZERO);
        end else if (c.base > sti_pkg::BASE_DEC &&
                     lc >= sti_pkg::CHAR_LA && lc <= sti_pkg::CHAR_LF) begin
          ok = 1'b1;
          d  = 4'(lc - sti_pkg::CHAR_LA) + 4'd10;
        end
        if (ok) begin
          // single 32x5 multiply-add, wraps mod 2^32
          a = 32'(a * 32'(c.base)) + 32'(d);
          e = cend_sat;
        end else begin
          c.phase = sti_pkg::PH_DONE;
        end
      end
      if ({1'b0, p} < MAXC) p = pos_inc[PW-1:0];
    end

    ctl_nxt  = c;
    acc_nxt  = a;
    pos_nxt  = p;
    cend_nxt = e;
  end

  assign cend_ext   = OW'(cend_nxt);
  assign end_offset = (cend_ext > OW'(255)) ? 8'hFF : cend_ext[sti_pkg::OFF_W-1:0];
  assign value      = ctl_nxt.neg ? (32'd0 - acc_nxt) : acc_nxt;
  assign stopped    = (ctl_nxt.phase == sti_pkg::PH_DONE);

endmodule
